// File: rtl/cobs_crc_frame_encoder_top_assert.svh
// Assertion macros for the COBS frame encoder.
`ifndef COBS_CRC_FRAME_ENCODER_TOP_ASSERT_SVH
`define COBS_CRC_FRAME_ENCODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define CCFE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ccfe: same-cycle check failed");
`define CCFE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ccfe: next-cycle check failed");
`else
`define CCFE_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define CCFE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: rtl/ccfe_pkg.sv
package ccfe_pkg;

   localparam int ReqDataWidth = 72;
   localparam int RspDataWidth = 72;

   localparam logic [7:0]  MaxPayloadBytes = 8'd255;
   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'h1021;
   localparam logic [7:0]  BlockFull = 8'hFF;
   localparam int          PendDepth = 254;

   localparam logic OpHeader  = 1'b0;
   localparam logic OpPayload = 1'b1;

   typedef struct packed {
      logic       push;
      logic [7:0] data;
      logic       eof;
      logic       end_run;
   } ccfe_emit_type;

   typedef struct packed {
      logic       wr_en;
      logic [7:0] wr_addr;
      logic [7:0] wr_data;
      logic       rd_en;
      logic [7:0] rd_addr;
   } ccfe_mem_req_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
      end
      return c;
   endfunction

endpackage

// File: rtl/cobs_crc_frame_encoder_top.sv
// Channel   Direction  Handshake              Contents
// req_      in         req_tvalid/req_tready  one header or one payload byte
// rsp_      out        rsp_tvalid/rsp_tready  up to eight encoded bytes, tlast ends the item
//
// A payload byte that closes no block is accepted, then written into the pending-block
// memory and folded into the CRC. Closing a block emits its code byte and then its
// pending bytes, read from the memory's read port one per cycle while the result
// channel takes them.
// Reset clears the frame state at once; the pending-block memory needs no clearing.
// A stalled result channel holds the sequencer at the next byte that has to leave, and no
// item is accepted until the current one has handed over its last result.
`include "cobs_crc_frame_encoder_top_assert.svh"

module cobs_crc_frame_encoder_top
   import ccfe_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // source_id, message_id, sequence_req, time_ms, payload_length, payload_byte
   input  logic [ReqDataWidth-1:0] req_tdata,
   // operation
   input  logic                    req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // packed_bytes, byte_count, zero fill
   output logic [RspDataWidth-1:0] rsp_tdata,
   // end_of_frame
   output logic                    rsp_tuser,
   output logic                    rsp_tlast
);

   ccfe_emit_type    emit;
   logic             emit_ready;
   ccfe_mem_req_type mem_req;
   logic [7:0]       mem_rd_data;
   logic [3:0]       rsp_count;

   assign rsp_count = rsp_tdata[67:64];

   ccfe_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .emit_ready  (emit_ready),
      .emit        (emit),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data)
   );

   ccfe_pend_mem u_pend_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   ccfe_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .emit_ready (emit_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `CCFE_ASSERT_NOW(a_eof_is_last, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast)
   `CCFE_ASSERT_NOW(a_inner_full, clock, reset, rsp_tvalid && !rsp_tlast, rsp_count == 4'd8)
   `CCFE_ASSERT_NOW(a_count_range, clock, reset, rsp_tvalid, rsp_count != 4'd0 && rsp_count <= 4'd8)
   `CCFE_ASSERT_NEXT(a_header_busy, clock, reset, req_tvalid && req_tready && req_tuser == OpHeader, !req_tready)

endmodule

// File: rtl/ccfe_pend_mem.sv
module ccfe_pend_mem
   import ccfe_pkg::*;
(
   input  logic             clock,
   input  ccfe_mem_req_type mem_req,
   output logic [7:0]       rd_data
);

   logic [7:0] mem [0:PendDepth-1];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ccfe_packer.sv
module ccfe_packer
   import ccfe_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  ccfe_emit_type           emit,
   output logic                    emit_ready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata,
   output logic                    rsp_tuser,
   output logic                    rsp_tlast
);

   logic [63:0] acc_ff, acc_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        eof_ff, eof_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_bytes_ff, rsp_bytes_in;
   logic [3:0]  rsp_cnt_ff, rsp_cnt_in;
   logic        rsp_eof_ff, rsp_eof_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit_ready = out_free;

   always_comb begin
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      eof_in       = eof_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_eof_in   = rsp_eof_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit.push) begin
         if (cnt_ff == 4'd8) begin
            rsp_valid_in = 1'b1;
            rsp_bytes_in = acc_ff;
            rsp_cnt_in   = cnt_ff;
            rsp_eof_in   = 1'b0;
            rsp_last_in  = 1'b0;
            acc_in       = {56'd0, emit.data};
            cnt_in       = 4'd1;
            eof_in       = emit.eof;
         end else begin
            acc_in = acc_ff | ({56'd0, emit.data} << {cnt_ff[2:0], 3'b000});
            cnt_in = cnt_ff + 4'd1;
            eof_in = eof_ff | emit.eof;
         end
      end else if (emit.end_run && cnt_ff != 4'd0) begin
         rsp_valid_in = 1'b1;
         rsp_bytes_in = acc_ff;
         rsp_cnt_in   = cnt_ff;
         rsp_eof_in   = eof_ff;
         rsp_last_in  = 1'b1;
         acc_in       = 64'd0;
         cnt_in       = 4'd0;
         eof_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= 64'd0;
         cnt_ff       <= 4'd0;
         eof_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         eof_ff       <= eof_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_eof_ff   <= rsp_eof_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_cnt_ff, rsp_bytes_ff};
   assign rsp_tuser  = rsp_eof_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: rtl/ccfe_seq.sv
module ccfe_seq
   import ccfe_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,
   input  logic                    req_tuser,
   input  logic                    emit_ready,
   output ccfe_emit_type           emit,
   output ccfe_mem_req_type        mem_req,
   input  logic [7:0]              mem_rd_data
);

   localparam logic [1:0] PhIdle  = 2'd0;
   localparam logic [1:0] PhRun   = 2'd1;
   localparam logic [1:0] PhClose = 2'd2;
   localparam logic [1:0] PhFlush = 2'd3;

   localparam logic [3:0] StOpen    = 4'd0;
   localparam logic [3:0] StHdrZero = 4'd1;
   localparam logic [3:0] StHdrSrc  = 4'd2;
   localparam logic [3:0] StHdrMsg  = 4'd3;
   localparam logic [3:0] StHdrSeq  = 4'd4;
   localparam logic [3:0] StHdrT0   = 4'd5;
   localparam logic [3:0] StHdrT1   = 4'd6;
   localparam logic [3:0] StHdrT2   = 4'd7;
   localparam logic [3:0] StHdrT3   = 4'd8;
   localparam logic [3:0] StHdrLen  = 4'd9;
   localparam logic [3:0] StPay     = 4'd10;
   localparam logic [3:0] StCrcLo   = 4'd11;
   localparam logic [3:0] StCrcHi   = 4'd12;
   localparam logic [3:0] StFinal   = 4'd13;
   localparam logic [3:0] StDelim   = 4'd14;
   localparam logic [3:0] StEnd     = 4'd15;

   logic [1:0]  phase_ff, phase_in;
   logic [3:0]  step_ff, step_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  code_ff, code_in;
   logic [7:0]  rem_ff, rem_in;
   logic        open_ff, open_in;
   logic        finish_ff, finish_in;
   logic [7:0]  flush_len_ff, flush_len_in;
   logic [7:0]  rd_idx_ff, rd_idx_in;

   logic [7:0]  src_ff, msg_ff, seqn_ff, len_ff, pay_ff;
   logic [31:0] time_ff;

   logic        accept;
   logic [7:0]  len_clamped;
   logic [7:0]  rem_dec;
   logic [7:0]  body_byte;
   logic [3:0]  step_after;
   logic [7:0]  code_inc;
   logic        crc_en;

   assign req_tready  = (phase_ff == PhIdle);
   assign accept      = req_tvalid && req_tready;
   assign len_clamped = (req_tdata[63:56] > MaxPayloadBytes) ? MaxPayloadBytes
                                                             : req_tdata[63:56];
   assign rem_dec     = (rem_ff != 8'd0) ? rem_ff - 8'd1 : 8'd0;
   assign code_inc    = code_ff + 8'd1;
   assign crc_en      = (step_ff >= StHdrZero) && (step_ff <= StPay);

   always_comb begin
      case (step_ff)
         StHdrSrc: body_byte = src_ff;
         StHdrMsg: body_byte = msg_ff;
         StHdrSeq: body_byte = seqn_ff;
         StHdrT0:  body_byte = time_ff[7:0];
         StHdrT1:  body_byte = time_ff[15:8];
         StHdrT2:  body_byte = time_ff[23:16];
         StHdrT3:  body_byte = time_ff[31:24];
         StHdrLen: body_byte = len_ff;
         StPay:    body_byte = pay_ff;
         StCrcLo:  body_byte = crc_ff[7:0];
         StCrcHi:  body_byte = crc_ff[15:8];
         default:  body_byte = 8'd0;
      endcase
   end

   always_comb begin
      if (step_ff == StHdrLen || step_ff == StPay) begin
         step_after = finish_ff ? StCrcLo : StEnd;
      end else begin
         step_after = step_ff + 4'd1;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      step_in      = step_ff;
      crc_in       = crc_ff;
      code_in      = code_ff;
      rem_in       = rem_ff;
      open_in      = open_ff;
      finish_in    = finish_ff;
      flush_len_in = flush_len_ff;
      rd_idx_in    = rd_idx_ff;
      emit         = '0;
      mem_req      = '0;
      unique case (phase_ff)
         PhIdle: begin
            if (accept) begin
               if (req_tuser == OpHeader) begin
                  crc_in    = CrcInit;
                  code_in   = 8'd1;
                  rem_in    = len_clamped;
                  open_in   = (len_clamped != 8'd0);
                  finish_in = (len_clamped == 8'd0);
                  phase_in  = PhRun;
                  step_in   = StOpen;
               end else if (open_ff) begin
                  rem_in    = rem_dec;
                  open_in   = (rem_dec != 8'd0);
                  finish_in = (rem_dec == 8'd0);
                  phase_in  = PhRun;
                  step_in   = StPay;
               end
            end
         end
         PhRun: begin
            if (step_ff == StOpen) begin
               if (emit_ready) begin
                  emit.push = 1'b1;
                  step_in   = StHdrZero;
               end
            end else if (step_ff == StFinal) begin
               phase_in = PhClose;
               step_in  = StDelim;
            end else if (step_ff == StDelim) begin
               if (emit_ready) begin
                  emit.push = 1'b1;
                  emit.eof  = 1'b1;
                  step_in   = StEnd;
               end
            end else if (step_ff == StEnd) begin
               if (emit_ready) begin
                  emit.end_run = 1'b1;
                  phase_in     = PhIdle;
               end
            end else begin
               if (crc_en) begin
                  crc_in = crc_byte(crc_ff, body_byte);
               end
               step_in = step_after;
               if (body_byte == 8'd0) begin
                  phase_in = PhClose;
               end else begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = code_ff - 8'd1;
                  mem_req.wr_data = body_byte;
                  code_in         = code_inc;
                  if (code_inc == BlockFull) begin
                     phase_in = PhClose;
                  end else if (step_ff == StPay && !finish_ff) begin
                     // Nothing has left for this item, so there is no run to close.
                     phase_in = PhIdle;
                  end
               end
            end
         end
         PhClose: begin
            if (emit_ready) begin
               emit.push    = 1'b1;
               emit.data    = code_ff;
               code_in      = 8'd1;
               flush_len_in = code_ff - 8'd1;
               if (code_ff != 8'd1) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = 8'd0;
                  rd_idx_in       = 8'd1;
                  phase_in        = PhFlush;
               end else begin
                  phase_in = PhRun;
               end
            end
         end
         PhFlush: begin
            if (emit_ready) begin
               emit.push = 1'b1;
               emit.data = mem_rd_data;
               if (rd_idx_ff != flush_len_ff) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = rd_idx_ff;
                  rd_idx_in       = rd_idx_ff + 8'd1;
               end else begin
                  phase_in = PhRun;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PhIdle;
         step_ff   <= StOpen;
         crc_ff    <= CrcInit;
         code_ff   <= 8'd1;
         rem_ff    <= 8'd0;
         open_ff   <= 1'b0;
         finish_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         step_ff   <= step_in;
         crc_ff    <= crc_in;
         code_ff   <= code_in;
         rem_ff    <= rem_in;
         open_ff   <= open_in;
         finish_ff <= finish_in;
      end
   end

   always_ff @(posedge clock) begin
      flush_len_ff <= flush_len_in;
      rd_idx_ff    <= rd_idx_in;
      if (accept) begin
         src_ff  <= req_tdata[7:0];
         msg_ff  <= req_tdata[15:8];
         seqn_ff <= req_tdata[23:16];
         time_ff <= req_tdata[55:24];
         len_ff  <= len_clamped;
         pay_ff  <= req_tdata[71:64];
      end
   end

endmodule

// File: bench/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ccfe_pkg::*;

   localparam int ClkPeriod  = 20;
   localparam int CycleLimit = 1_000_000;
   localparam int RandItems  = 200;
   localparam int ReportCap  = 20;

   typedef struct {
      logic [63:0] bytes;
      logic [3:0]  count;
      logic        eof;
      logic        last;
   } enc_word_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata;
   logic                    req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    rsp_tuser;
   logic                    rsp_tlast;

   logic [15:0]  crc_q;
   int           code_q;
   logic [7:0]   blk_q [PendDepth];
   int           left_q;
   logic         open_q;
   logic [7:0]   enc_bytes [$];
   logic         enc_eof;
   enc_word_type expected_words [$];

   bit  calm;
   int  hold_request;
   int  mismatches;
   int  cycle_count;
   int  items_accepted;
   int  frames_started;
   int  words_checked;

   cobs_crc_frame_encoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #(ClkPeriod / 2) clock = ~clock;

   function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (r[15]) r = {r[14:0], 1'b0} ^ CrcPoly;
         else r = {r[14:0], 1'b0};
      end
      return r;
   endfunction

   function void close_cobs_block();
      int n;
      n = code_q - 1;
      if (n > PendDepth) n = PendDepth;
      enc_bytes.push_back(code_q[7:0]);
      for (int i = 0; i < n; i++) enc_bytes.push_back(blk_q[i]);
      code_q = 1;
   endfunction

   function void cobs_push(input logic [7:0] b);
      if (b == 8'h00) begin
         close_cobs_block();
      end else begin
         blk_q[code_q - 1] = b;
         code_q++;
         if (code_q >= int'(BlockFull)) close_cobs_block();
      end
   endfunction

   function void body_push(input logic [7:0] b);
      crc_q = crc16_step(crc_q, b);
      cobs_push(b);
   endfunction

   function void close_frame();
      logic [15:0] c;
      c = crc_q;
      cobs_push(c[7:0]);
      cobs_push(c[15:8]);
      close_cobs_block();
      enc_bytes.push_back(8'h00);
      open_q = 1'b0;
      left_q = 0;
      enc_eof = 1'b1;
   endfunction

   function void encode_item(input logic op, input logic [ReqDataWidth-1:0] data);
      int           len;
      int           nwords;
      int           cnt;
      enc_word_type w;
      enc_bytes.delete();
      enc_eof = 1'b0;
      if (op == OpHeader) begin
         frames_started++;
         len = int'(data[63:56]);
         if (len > int'(MaxPayloadBytes)) len = int'(MaxPayloadBytes);
         open_q = 1'b1;
         crc_q = CrcInit;
         code_q = 1;
         enc_bytes.push_back(8'h00);
         body_push(8'h00);
         body_push(data[7:0]);
         body_push(data[15:8]);
         body_push(data[23:16]);
         body_push(data[31:24]);
         body_push(data[39:32]);
         body_push(data[47:40]);
         body_push(data[55:48]);
         body_push(len[7:0]);
         left_q = len;
         if (len == 0) close_frame();
      end else if (open_q) begin
         body_push(data[71:64]);
         if (left_q > 0) left_q--;
         if (left_q == 0) close_frame();
      end
      nwords = (enc_bytes.size() + 7) / 8;
      for (int k = 0; k < nwords; k++) begin
         cnt = enc_bytes.size() - 8 * k;
         if (cnt > 8) cnt = 8;
         w.bytes = '0;
         for (int j = 0; j < cnt; j++) w.bytes[8 * j +: 8] = enc_bytes[8 * k + j];
         w.count = cnt[3:0];
         w.last = (k == nwords - 1);
         w.eof = enc_eof && w.last;
         expected_words.push_back(w);
      end
   endfunction

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      if (mismatches < ReportCap)
         $display("%0t: %s mismatch, got %h, expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic check_word();
      enc_word_type w;
      words_checked++;
      if (expected_words.size() == 0) begin
         flag_mismatch("unexpected result", rsp_tdata[63:0], 64'h0);
      end else begin
         w = expected_words.pop_front();
         if (rsp_tdata[63:0] !== w.bytes) flag_mismatch("packed bytes", rsp_tdata[63:0], w.bytes);
         if (rsp_tdata[67:64] !== w.count)
            flag_mismatch("byte count", 64'(rsp_tdata[67:64]), 64'(w.count));
         if (rsp_tdata[71:68] !== 4'h0)
            flag_mismatch("zero fill", 64'(rsp_tdata[71:68]), 64'h0);
         if (rsp_tuser !== w.eof) flag_mismatch("end of frame", 64'(rsp_tuser), 64'(w.eof));
         if (rsp_tlast !== w.last) flag_mismatch("last of run", 64'(rsp_tlast), 64'(w.last));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_word();
   end

   initial begin
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            rsp_tready <= 1'b0;
            n = hold_request;
            hold_request = 0;
            repeat (n) @(negedge clock);
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 10);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[cobs_crc_frame_encoder_top] ERROR");
      $finish;
   end

   function automatic logic [ReqDataWidth-1:0] header_word(
      input logic [7:0] src, input logic [7:0] mid, input logic [7:0] seq,
      input logic [31:0] stamp, input logic [7:0] len);
      logic [7:0] junk;
      junk = 8'($urandom_range(255));
      return {junk, len, stamp, seq, mid, src};
   endfunction

   function automatic logic [ReqDataWidth-1:0] payload_word(input logic [7:0] b);
      return {b, $urandom, $urandom};
   endfunction

   function automatic logic [7:0] rand_byte(input int zero_pct);
      int r;
      r = $urandom_range(99);
      if (r < zero_pct) return 8'h00;
      if (r < zero_pct + 5) return 8'hFF;
      return 8'($urandom_range(255, 1));
   endfunction

   task automatic send_item(input logic op, input logic [ReqDataWidth-1:0] data);
      @(negedge clock);
      if (!calm && $urandom_range(99) < 10) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      encode_item(op, data);
      items_accepted++;
   endtask

   task automatic send_header(input logic [7:0] src, input logic [7:0] mid,
                              input logic [7:0] seq, input logic [31:0] stamp,
                              input logic [7:0] len);
      send_item(OpHeader, header_word(src, mid, seq, stamp, len));
   endtask

   task automatic send_payload(input logic [7:0] b);
      send_item(OpPayload, payload_word(b));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_payload(8'h5A);
      send_header(8'h00, 8'h00, 8'h00, 32'h0000_0000, 8'd0);
      send_header(8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'd3);
      send_payload(8'h00);
      send_payload(8'hFF);
      send_payload(8'h01);
      send_header(8'h12, 8'h34, 8'h56, 32'h8000_0001, 8'd5);
      send_payload(8'h80);
      send_payload(8'h7F);
      send_header(8'hA5, 8'h5A, 8'h01, 32'h0102_0304, 8'd1);
      send_payload(8'h80);
      send_payload(8'h33);
      send_header(8'h01, 8'h00, 8'h02, 32'h00FF_00FF, 8'd2);
      send_payload(8'h00);
      send_payload(8'h00);
      wait_drained();
   endtask

   // The body after the leading zero marker is exactly one full block of nonzero bytes
   // ending on the high CRC byte, so the frame must close with an extra code byte.
   task automatic test_full_block();
      logic [7:0]  hdr [8];
      logic [7:0]  pay [$];
      logic [15:0] c;
      localparam int PayLen = 244;
      calm = 1'b1;
      for (int i = 0; i < 8; i++) hdr[i] = 8'($urandom_range(255, 1));
      hdr[7] = 8'(PayLen);
      for (int i = 0; i < PayLen; i++) pay.push_back(8'($urandom_range(255, 1)));
      do begin
         c = crc16_step(CrcInit, 8'h00);
         for (int i = 0; i < 8; i++) c = crc16_step(c, hdr[i]);
         for (int i = 0; i < PayLen; i++) c = crc16_step(c, pay[i]);
         if (c[7:0] == 8'h00 || c[15:8] == 8'h00)
            pay[PayLen - 1] = (pay[PayLen - 1] == 8'hFF) ? 8'h01 : pay[PayLen - 1] + 8'h01;
      end while (c[7:0] == 8'h00 || c[15:8] == 8'h00);
      send_header(hdr[0], hdr[1], hdr[2], {hdr[6], hdr[5], hdr[4], hdr[3]}, hdr[7]);
      foreach (pay[i]) send_payload(pay[i]);
      wait_drained();
      calm = 1'b0;
   endtask

   task automatic test_backpressure();
      hold_request = 400;
      send_header(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                  $urandom, 8'd30);
      for (int i = 0; i < 30; i++) send_payload(rand_byte(30));
      wait_drained();
   endtask

   task automatic test_random_frames();
      int useful;
      int len;
      int n;
      useful = 0;
      while (useful < RandItems) begin
         if ($urandom_range(99) < 4) len = $urandom_range(255, 128);
         else len = $urandom_range(24, 0);
         send_header(8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), $urandom, len[7:0]);
         useful++;
         n = len;
         if (len > 0 && $urandom_range(99) < 10) n = $urandom_range(len - 1, 0);
         for (int i = 0; i < n; i++) begin
            send_payload(rand_byte(len >= 128 ? 2 : 20));
            useful++;
         end
         if ($urandom_range(99) < 8) send_payload(rand_byte(20));
      end
      wait_drained();
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = OpHeader;
      calm         = 1'b0;
      hold_request = 0;
      mismatches   = 0;
      items_accepted = 0;
      frames_started = 0;
      words_checked  = 0;
      crc_q  = CrcInit;
      code_q = 1;
      left_q = 0;
      open_q = 1'b0;
      enc_eof = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_full_block();
      test_backpressure();
      test_random_frames();

      wait_drained();
      repeat (300) @(posedge clock);
      if (expected_words.size() != 0)
         flag_mismatch("missing results", 64'(expected_words.size()), 64'h0);

      $display("Sent %0d items opening %0d frames and checked %0d encoded words,",
               items_accepted, frames_started, words_checked);
      $display("including discarded frames, stray bytes, a full final block and a long stall.");
      if (mismatches == 0) $display("[cobs_crc_frame_encoder_top] OK");
      else $display("[cobs_crc_frame_encoder_top] ERROR");
      $finish;
   end

endmodule

// File: cobs_crc_frame_encoder_top.f
+incdir+rtl
rtl/ccfe_pkg.sv
rtl/ccfe_pend_mem.sv
rtl/ccfe_packer.sv
rtl/ccfe_seq.sv
rtl/cobs_crc_frame_encoder_top.sv
bench/tb.sv
